// ----- sv/pts_pkg.sv -----
// Package for the polar target-speed interpolator.
// Holds the widths, constants, codes and transaction types shared by every file but pts_ram.
// Depends on nothing.
`default_nettype none

package pts_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLUMNS = 64;
    localparam int FRAC_BITS   = 16;

    localparam int WSPEED_W    = 32;
    localparam int WANGLE_W    = 26;
    localparam int VALUE_W     = 31;
    localparam int INDEX_W     = 11;
    localparam int STEP_W      = 31;
    localparam int ROWS_FLD_W  = 6;
    localparam int COLS_FLD_W  = 7;
    localparam int SPEED_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam int TABLE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int QROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QB          = QROW_W + FRAC_BITS;

    localparam longint FULL_TURN = longint'(360) << FRAC_BITS;
    localparam int ANG_W       = $clog2(FULL_TURN);
    localparam int ANGX_W      = (((ANG_W + 1) > WANGLE_W) ? (ANG_W + 1) : WANGLE_W) + 1;
    localparam logic signed [ANGX_W-1:0] TURN = ANGX_W'(FULL_TURN);
    localparam int X_W         = ANG_W + COL_W;
    localparam int RECIP_SHIFT = X_W + 8;
    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << RECIP_SHIFT) / 64'd360);
    localparam logic [X_W-1:0] DEGREES = X_W'(360);
    localparam int Q0_W        = X_W - 8;
    localparam int IDXA_W      = COL_W + FRAC_BITS;

    localparam int WEIGHT_W    = FRAC_BITS + 1;
    localparam logic [WEIGHT_W-1:0] ONE_Q = WEIGHT_W'(longint'(1) << FRAC_BITS);
    localparam int PROD_W      = VALUE_W + WEIGHT_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [SPEED_W-1:0] EMPTY_SPEED =
        SPEED_W'(-(longint'(1) << FRAC_BITS));

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_STEP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_COLUMNS = 2'd2;

    typedef struct packed {
        logic                       action;
        logic [INDEX_W-1:0]         entry_index;
        logic [VALUE_W-1:0]         entry_value;
        logic signed [WSPEED_W-1:0] wind_speed;
        logic signed [WANGLE_W-1:0] wind_angle;
    } item_t;

    typedef struct packed {
        logic action;
        logic empty;
        logic neg;
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic                 sat;
        logic [COL_W-1:0]     col;
        logic [COL_W-1:0]     ncol;
        logic [FRAC_BITS-1:0] lam_a;
        logic [INDEX_W-1:0]   entry_index;
        logic [VALUE_W-1:0]   entry_value;
    } side_t;

endpackage

`default_nettype wire

// ----- sv/pts_if.sv -----
// Channel interfaces for the polar target-speed interpolator.
// Valid/ready handshake with the item and result payloads; depends on pts_pkg.
`default_nettype none

interface pts_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [pts_pkg::INDEX_W-1:0]         entry_index;
    logic [pts_pkg::VALUE_W-1:0]         entry_value;
    logic signed [pts_pkg::WSPEED_W-1:0] wind_speed;
    logic signed [pts_pkg::WANGLE_W-1:0] wind_angle;

    modport source (output valid, action, entry_index, entry_value, wind_speed, wind_angle,
                    input ready);
    modport sink (input valid, action, entry_index, entry_value, wind_speed, wind_angle,
                  output ready);
endinterface

interface pts_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pts_pkg::SPEED_W-1:0] target_speed;
    logic                               table_empty;

    modport source (output valid, target_speed, table_empty, input ready);
    modport sink (input valid, target_speed, table_empty, output ready);
endinterface

`default_nettype wire

// ----- sv/pts_ram.sv -----
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]              rdata0,
    output logic [WIDTH-1:0]              rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

// ----- sv/pts_front.sv -----
// Front pipeline: angle wrap, column index by reciprocal, range and empty checks.
// Six register stages; depends on pts_pkg.
`default_nettype none

module pts_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire pts_pkg::item_t                in_item,
    input  wire logic [pts_pkg::ROW_W-1:0]     rows,
    input  wire logic [pts_pkg::COL_W-1:0]     cols,
    input  wire logic [pts_pkg::STEP_W-1:0]    step,
    output logic                               out_valid,
    output pts_pkg::side_t                     out_side,
    output logic [pts_pkg::WSPEED_W-2:0]       out_ws
);

    localparam int LIM_W = pts_pkg::ROW_W + pts_pkg::STEP_W;

    logic                                   a_vld_reg;
    pts_pkg::item_t                         a_item_reg;
    logic                                   b_vld_reg;
    pts_pkg::side_t                         b_side_reg;
    logic [pts_pkg::WSPEED_W-2:0]           b_ws_reg;
    logic signed [pts_pkg::ANGX_W-1:0]      b_ang_reg;
    logic                                   c_vld_reg;
    pts_pkg::side_t                         c_side_reg;
    logic [pts_pkg::WSPEED_W-2:0]           c_ws_reg;
    logic [pts_pkg::X_W-1:0]                c_x_reg;
    logic                                   d_vld_reg;
    pts_pkg::side_t                         d_side_reg;
    logic [pts_pkg::WSPEED_W-2:0]           d_ws_reg;
    logic [pts_pkg::X_W-1:0]                d_x_reg;
    logic [2*pts_pkg::X_W-1:0]              d_p_reg;
    logic                                   e_vld_reg;
    pts_pkg::side_t                         e_side_reg;
    logic [pts_pkg::WSPEED_W-2:0]           e_ws_reg;
    logic [pts_pkg::Q0_W-1:0]               e_q0_reg;
    logic [pts_pkg::X_W-1:0]                e_rem_reg;
    logic                                   f_vld_reg;
    pts_pkg::side_t                         f_side_reg;
    logic [pts_pkg::WSPEED_W-2:0]           f_ws_reg;

    logic signed [pts_pkg::ANGX_W-1:0]      ang_ext;
    logic signed [pts_pkg::ANGX_W-1:0]      ang1;
    logic signed [pts_pkg::ANGX_W-1:0]      ang2;
    logic [LIM_W-1:0]                       limit;
    pts_pkg::side_t                         b_side_next;
    logic [pts_pkg::Q0_W-1:0]               q0;
    logic [pts_pkg::IDXA_W-1:0]             idx_a;
    logic [pts_pkg::COL_W-1:0]              col_raw;
    logic [pts_pkg::COL_W-1:0]              col;
    logic [pts_pkg::COL_W-1:0]              col_inc;
    pts_pkg::side_t                         f_side_next;

    assign ang_ext = {{(pts_pkg::ANGX_W - pts_pkg::WANGLE_W){a_item_reg.wind_angle[pts_pkg::WANGLE_W-1]}},
                      a_item_reg.wind_angle};
    assign limit   = LIM_W'(rows) * LIM_W'(step);

    always_comb
    begin
        if (ang_ext < 0)
        begin
            ang1 = ang_ext + pts_pkg::TURN;
        end
        else if (ang_ext >= pts_pkg::TURN)
        begin
            ang1 = ang_ext - pts_pkg::TURN;
        end
        else
        begin
            ang1 = ang_ext;
        end
    end

    always_comb
    begin
        b_side_next             = '0;
        b_side_next.kind.action = a_item_reg.action;
        b_side_next.kind.empty  = (rows == '0) || (cols == '0);
        b_side_next.kind.neg    = a_item_reg.wind_speed[pts_pkg::WSPEED_W-1];
        b_side_next.sat         = LIM_W'(a_item_reg.wind_speed[pts_pkg::WSPEED_W-2:0]) >= limit;
        b_side_next.entry_index = a_item_reg.entry_index;
        b_side_next.entry_value = a_item_reg.entry_value;
    end

    assign ang2 = (b_ang_reg < 0) ? (b_ang_reg + pts_pkg::TURN) : b_ang_reg;

    assign q0      = pts_pkg::Q0_W'(d_p_reg >> pts_pkg::RECIP_SHIFT);
    assign idx_a   = pts_pkg::IDXA_W'(e_q0_reg + pts_pkg::Q0_W'(e_rem_reg >= pts_pkg::DEGREES));
    assign col_raw = idx_a[pts_pkg::IDXA_W-1:pts_pkg::FRAC_BITS];
    assign col     = (col_raw >= cols) ? pts_pkg::COL_W'(cols - pts_pkg::COL_W'(1)) : col_raw;
    assign col_inc = pts_pkg::COL_W'(col + pts_pkg::COL_W'(1));

    always_comb
    begin
        f_side_next       = e_side_reg;
        f_side_next.col   = col;
        f_side_next.ncol  = (col_inc == cols) ? '0 : col_inc;
        f_side_next.lam_a = idx_a[pts_pkg::FRAC_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            b_side_reg <= b_side_next;
            b_ws_reg   <= a_item_reg.wind_speed[pts_pkg::WSPEED_W-2:0];
            b_ang_reg  <= ang1;
            c_side_reg <= b_side_reg;
            c_ws_reg   <= b_ws_reg;
            c_x_reg    <= pts_pkg::X_W'(ang2[pts_pkg::ANG_W-1:0]) * pts_pkg::X_W'(cols);
            d_side_reg <= c_side_reg;
            d_ws_reg   <= c_ws_reg;
            d_x_reg    <= c_x_reg;
            d_p_reg    <= (2*pts_pkg::X_W)'(c_x_reg) * (2*pts_pkg::X_W)'(pts_pkg::RECIP);
            e_side_reg <= d_side_reg;
            e_ws_reg   <= d_ws_reg;
            e_q0_reg   <= q0;
            e_rem_reg  <= d_x_reg - (pts_pkg::X_W'(q0) * pts_pkg::DEGREES);
            f_side_reg <= f_side_next;
            f_ws_reg   <= e_ws_reg;
        end
    end

    assign out_valid = f_vld_reg;
    assign out_side  = f_side_reg;
    assign out_ws    = f_ws_reg;

endmodule

`default_nettype wire

// ----- sv/pts_div.sv -----
// Pipelined restoring divider for the wind-speed row index, one quotient bit per stage.
// Carries the transaction sideband alongside; depends on pts_pkg.
`default_nettype none

module pts_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire pts_pkg::side_t                in_side,
    input  wire logic [pts_pkg::WSPEED_W-2:0]  in_ws,
    input  wire logic [pts_pkg::STEP_W-1:0]    divisor,
    output logic                               out_valid,
    output pts_pkg::side_t                     out_side,
    output logic [pts_pkg::QB-1:0]             out_quot
);

    typedef struct packed {
        logic [pts_pkg::STEP_W-1:0] rem;
        logic [pts_pkg::QB-1:0]     quot;
        logic [pts_pkg::QROW_W-1:0] wlo;
        pts_pkg::side_t             side;
    } dstage_t;

    dstage_t stage_reg [pts_pkg::QB];
    logic    vld_reg   [pts_pkg::QB];
    dstage_t init;

    assign init.rem  = pts_pkg::STEP_W'(in_ws >> pts_pkg::QROW_W);
    assign init.quot = '0;
    assign init.wlo  = in_ws[pts_pkg::QROW_W-1:0];
    assign init.side = in_side;

    for (genvar j = 0; j < pts_pkg::QB; j++)
    begin : g_stage
        dstage_t                     cur;
        dstage_t                     nxt;
        logic                        cur_vld;
        logic                        nbit;
        logic [pts_pkg::STEP_W:0]    trial;
        logic                        ge;

        if (j == 0)
        begin : g_first
            assign cur     = init;
            assign cur_vld = in_valid;
        end
        else
        begin : g_rest
            assign cur     = stage_reg[j-1];
            assign cur_vld = vld_reg[j-1];
        end

        if ((pts_pkg::QB - 1 - j) >= pts_pkg::FRAC_BITS)
        begin : g_bit
            assign nbit = cur.wlo[pts_pkg::QB-1-j-pts_pkg::FRAC_BITS];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {cur.rem, nbit};
        assign ge    = trial >= {1'b0, divisor};

        always_comb
        begin
            nxt      = cur;
            nxt.rem  = ge ? pts_pkg::STEP_W'(trial - {1'b0, divisor})
                          : trial[pts_pkg::STEP_W-1:0];
            nxt.quot = {cur.quot[pts_pkg::QB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[j] <= nxt;
            end
        end
    end

    assign out_valid = vld_reg[pts_pkg::QB-1];
    assign out_side  = stage_reg[pts_pkg::QB-1].side;
    assign out_quot  = stage_reg[pts_pkg::QB-1].quot;

endmodule

`default_nettype wire

// ----- sv/pts_back.sv -----
// Back pipeline: table addressing and writes, four reads, two-level blend, result register.
// Holds the table in two pts_ram copies; depends on pts_pkg and pts_ram.
`default_nettype none

module pts_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire pts_pkg::side_t                in_side,
    input  wire logic [pts_pkg::QB-1:0]        in_quot,
    input  wire logic [pts_pkg::ROW_W-1:0]     rows,
    input  wire logic [pts_pkg::COL_W-1:0]     cols,
    output logic                               out_valid,
    output logic signed [pts_pkg::SPEED_W-1:0] out_speed,
    output logic                               out_empty
);

    localparam int AW = pts_pkg::ADDR_W;
    localparam int PW = pts_pkg::PROD_W;
    localparam int VW = pts_pkg::VALUE_W;
    localparam int WW = pts_pkg::WEIGHT_W;

    logic [pts_pkg::ROW_W-1:0]     row_lo;
    logic [pts_pkg::FRAC_BITS-1:0] lam_s;
    logic [AW-1:0]                 base_lo;
    logic [AW-1:0]                 base_hi;
    logic                          wr_en;
    logic [VW-1:0]                 lo_c;
    logic [VW-1:0]                 lo_n;
    logic [VW-1:0]                 hi_c;
    logic [VW-1:0]                 hi_n;

    logic                          r_vld_reg;
    pts_pkg::kind_t                r_kind_reg;
    logic [pts_pkg::FRAC_BITS-1:0] r_lam_a_reg;
    logic [pts_pkg::FRAC_BITS-1:0] r_lam_s_reg;
    logic                          r_zero_lo_reg;
    logic                          r_zero_hi_reg;
    logic                          m1_vld_reg;
    pts_pkg::kind_t                m1_kind_reg;
    logic [pts_pkg::FRAC_BITS-1:0] m1_lam_s_reg;
    logic [PW-1:0]                 m1_p0_reg;
    logic [PW-1:0]                 m1_p1_reg;
    logic [PW-1:0]                 m1_p2_reg;
    logic [PW-1:0]                 m1_p3_reg;
    logic                          m2_vld_reg;
    pts_pkg::kind_t                m2_kind_reg;
    logic [pts_pkg::FRAC_BITS-1:0] m2_lam_s_reg;
    logic [VW-1:0]                 m2_s_lo_reg;
    logic [VW-1:0]                 m2_s_hi_reg;
    logic                          m3_vld_reg;
    pts_pkg::kind_t                m3_kind_reg;
    logic [PW-1:0]                 m3_t0_reg;
    logic [PW-1:0]                 m3_t1_reg;
    logic                          out_vld_reg;
    logic signed [pts_pkg::SPEED_W-1:0] speed_reg;
    logic                          empty_reg;

    logic [VW-1:0]                 blended;
    logic signed [pts_pkg::SPEED_W-1:0] speed_next;
    logic                          empty_next;
    logic [WW-1:0]                 wa_lo;
    logic [WW-1:0]                 wa_hi;
    logic [WW-1:0]                 ws_lo;
    logic [WW-1:0]                 ws_hi;
    logic [VW-1:0]                 a_lo;
    logic [VW-1:0]                 b_lo;
    logic [VW-1:0]                 a_hi;
    logic [VW-1:0]                 b_hi;

    assign row_lo  = in_side.sat ? rows
                                 : pts_pkg::ROW_W'(in_quot[pts_pkg::QB-1:pts_pkg::FRAC_BITS]);
    assign lam_s   = in_side.sat ? '0 : in_quot[pts_pkg::FRAC_BITS-1:0];
    assign base_hi = AW'(AW'(row_lo) * AW'(cols));
    assign base_lo = AW'(base_hi - AW'(cols));
    assign wr_en   = adv && in_valid && (in_side.kind.action == pts_pkg::ACT_WRITE)
                     && (32'(in_side.entry_index) < 32'(pts_pkg::TABLE_DEPTH));

    pts_ram #(
        .WIDTH (VW),
        .DEPTH (pts_pkg::TABLE_DEPTH)
    ) u_ram_lo (
        .clk    (clk),
        .we     (wr_en),
        .waddr  (AW'(in_side.entry_index)),
        .wdata  (in_side.entry_value),
        .re     (adv),
        .raddr0 (AW'(base_lo + AW'(in_side.col))),
        .raddr1 (AW'(base_lo + AW'(in_side.ncol))),
        .rdata0 (lo_c),
        .rdata1 (lo_n)
    );

    pts_ram #(
        .WIDTH (VW),
        .DEPTH (pts_pkg::TABLE_DEPTH)
    ) u_ram_hi (
        .clk    (clk),
        .we     (wr_en),
        .waddr  (AW'(in_side.entry_index)),
        .wdata  (in_side.entry_value),
        .re     (adv),
        .raddr0 (AW'(base_hi + AW'(in_side.col))),
        .raddr1 (AW'(base_hi + AW'(in_side.ncol))),
        .rdata0 (hi_c),
        .rdata1 (hi_n)
    );

    // drop reads of the calm row and of the row above a saturated speed
    assign a_lo  = r_zero_lo_reg ? '0 : lo_c;
    assign b_lo  = r_zero_lo_reg ? '0 : lo_n;
    assign a_hi  = r_zero_hi_reg ? '0 : hi_c;
    assign b_hi  = r_zero_hi_reg ? '0 : hi_n;
    assign wa_hi = WW'(r_lam_a_reg);
    assign wa_lo = WW'(pts_pkg::ONE_Q - wa_hi);
    assign ws_hi = WW'(m2_lam_s_reg);
    assign ws_lo = WW'(pts_pkg::ONE_Q - ws_hi);

    assign blended = VW'((m3_t0_reg + m3_t1_reg) >> pts_pkg::FRAC_BITS);

    always_comb
    begin
        speed_next = '0;
        empty_next = 1'b0;
        if (m3_kind_reg.action == pts_pkg::ACT_QUERY)
        begin
            if (m3_kind_reg.empty)
            begin
                speed_next = pts_pkg::EMPTY_SPEED;
                empty_next = 1'b1;
            end
            else if (!m3_kind_reg.neg)
            begin
                speed_next = {1'b0, blended};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg   <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_vld_reg   <= in_valid;
            m1_vld_reg  <= r_vld_reg;
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            out_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_kind_reg    <= in_side.kind;
            r_lam_a_reg   <= in_side.lam_a;
            r_lam_s_reg   <= lam_s;
            r_zero_lo_reg <= (row_lo == '0);
            r_zero_hi_reg <= in_side.sat;
            m1_kind_reg   <= r_kind_reg;
            m1_lam_s_reg  <= r_lam_s_reg;
            m1_p0_reg     <= PW'(a_lo) * PW'(wa_lo);
            m1_p1_reg     <= PW'(b_lo) * PW'(wa_hi);
            m1_p2_reg     <= PW'(a_hi) * PW'(wa_lo);
            m1_p3_reg     <= PW'(b_hi) * PW'(wa_hi);
            m2_kind_reg   <= m1_kind_reg;
            m2_lam_s_reg  <= m1_lam_s_reg;
            m2_s_lo_reg   <= VW'((m1_p0_reg + m1_p1_reg) >> pts_pkg::FRAC_BITS);
            m2_s_hi_reg   <= VW'((m1_p2_reg + m1_p3_reg) >> pts_pkg::FRAC_BITS);
            m3_kind_reg   <= m2_kind_reg;
            m3_t0_reg     <= PW'(m2_s_lo_reg) * PW'(ws_lo);
            m3_t1_reg     <= PW'(m2_s_hi_reg) * PW'(ws_hi);
            speed_reg     <= speed_next;
            empty_reg     <= empty_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_speed = speed_reg;
    assign out_empty = empty_reg;

endmodule

`default_nettype wire

// ----- sv/polar_target_speed_interpolator_top.sv -----
// One transaction per cycle while the result register is not waiting to be taken.
// Throughput is set by the four table reads, served by two dual-read copies of the table.
// The whole pipeline holds while the result register waits to be taken.
// Reset clears all valid bits and the configuration registers (step 1.0, counts zero);
// table contents are undefined until written.
// Depends on pts_pkg, pts_if, pts_front, pts_div, pts_back.
`default_nettype none

module polar_target_speed_interpolator_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pts_in_if.sink                                 item,
    pts_out_if.source                              result,
    input  wire logic                              cfg_write,
    input  wire logic [pts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [pts_pkg::STEP_W-1:0]     speed_step_reg;
    logic [pts_pkg::ROWS_FLD_W-1:0] speed_rows_reg;
    logic [pts_pkg::COLS_FLD_W-1:0] angle_columns_reg;

    logic [pts_pkg::ROW_W-1:0]      rows;
    logic [pts_pkg::COL_W-1:0]      cols;
    logic [pts_pkg::STEP_W-1:0]     step;
    logic                           adv;
    logic                           out_vld;
    pts_pkg::item_t                 in_item;
    logic                           f_vld;
    pts_pkg::side_t                 f_side;
    logic [pts_pkg::WSPEED_W-2:0]   f_ws;
    logic                           d_vld;
    pts_pkg::side_t                 d_side;
    logic [pts_pkg::QB-1:0]         d_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_step_reg    <= pts_pkg::STEP_RESET;
            speed_rows_reg    <= '0;
            angle_columns_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pts_pkg::CFG_SPEED_STEP:
                begin
                    speed_step_reg <= cfg_data;
                end
                pts_pkg::CFG_SPEED_ROWS:
                begin
                    speed_rows_reg <= cfg_data[pts_pkg::ROWS_FLD_W-1:0];
                end
                pts_pkg::CFG_ANGLE_COLUMNS:
                begin
                    angle_columns_reg <= cfg_data[pts_pkg::COLS_FLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rows = (int'(speed_rows_reg) > pts_pkg::MAX_ROWS) ? pts_pkg::ROW_W'(pts_pkg::MAX_ROWS)
                                                            : pts_pkg::ROW_W'(speed_rows_reg);
    assign cols = (int'(angle_columns_reg) > pts_pkg::MAX_COLUMNS)
                  ? pts_pkg::COL_W'(pts_pkg::MAX_COLUMNS) : pts_pkg::COL_W'(angle_columns_reg);
    assign step = (speed_step_reg == '0) ? pts_pkg::STEP_W'(1) : speed_step_reg;

    assign adv        = !out_vld || result.ready;
    assign item.ready = adv;

    assign in_item.action      = item.action;
    assign in_item.entry_index = item.entry_index;
    assign in_item.entry_value = item.entry_value;
    assign in_item.wind_speed  = item.wind_speed;
    assign in_item.wind_angle  = item.wind_angle;

    pts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item.valid),
        .in_item   (in_item),
        .rows      (rows),
        .cols      (cols),
        .step      (step),
        .out_valid (f_vld),
        .out_side  (f_side),
        .out_ws    (f_ws)
    );

    pts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_vld),
        .in_side   (f_side),
        .in_ws     (f_ws),
        .divisor   (step),
        .out_valid (d_vld),
        .out_side  (d_side),
        .out_quot  (d_quot)
    );

    pts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld),
        .in_side   (d_side),
        .in_quot   (d_quot),
        .rows      (rows),
        .cols      (cols),
        .out_valid (out_vld),
        .out_speed (result.target_speed),
        .out_empty (result.table_empty)
    );

    assign result.valid = out_vld;

endmodule

`default_nettype wire

// ----- sv/pts_checker.sv -----
// Port-level checker for the polar target-speed interpolator, bound to the top level.
// Depends on pts_pkg.
`default_nettype none

module pts_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              item_valid,
    input wire logic                              item_ready,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic signed [pts_pkg::SPEED_W-1:0] target_speed,
    input wire logic                              table_empty
);

    // hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(target_speed)
                                          && $stable(table_empty))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item refused without a stalled result");

    a_empty_speed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && table_empty |-> target_speed == pts_pkg::EMPTY_SPEED)
        else $error("empty flag without minus one");

    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !table_empty |-> !target_speed[pts_pkg::SPEED_W-1])
        else $error("negative speed on a non-empty result");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && item_valid |-> item_ready)
        else $error("item refused while output register empty");

endmodule

bind polar_target_speed_interpolator_top pts_checker u_pts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .target_speed (result.target_speed),
    .table_empty  (result.table_empty)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the polar target-speed interpolator: drives write and query transactions
// against its own table interpolation predictor and checks every result in order.
// Depends on pts_pkg, pts_if and polar_target_speed_interpolator_top.
`timescale 1ns / 100ps

module tb_top;

    localparam int FILL_ENTRIES = 512;

    typedef struct {
        logic signed [pts_pkg::SPEED_W-1:0] speed;
        logic                               empty;
    } speed_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write;
    logic [pts_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data;

    pts_in_if  in_ch();
    pts_out_if out_ch();

    polar_target_speed_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    longint        step_reg;
    longint        rows_reg;
    longint        cols_reg;
    longint        speed_table_copy [pts_pkg::TABLE_DEPTH];
    speed_result_t pending_speeds [$];
    int            errors = 0;
    int            burst_left = 0;
    bit            gaps_on = 1'b1;

    function automatic longint mix(longint a, longint b, longint lam);
        return (a * ((longint'(1) << pts_pkg::FRAC_BITS) - lam) + b * lam)
               >>> pts_pkg::FRAC_BITS;
    endfunction

    function automatic longint speed_in_row(longint row, longint ang, longint cols);
        longint pos;
        longint col;
        longint nxt;
        longint base;
        if (row == 0)
            return 0;
        pos = (ang * cols) / 360;
        col = pos >>> pts_pkg::FRAC_BITS;
        if (col >= cols)
            col = cols - 1;
        nxt = (col + 1) % cols;
        base = (row - 1) * cols;
        return mix(speed_table_copy[base + col], speed_table_copy[base + nxt],
                   pos & ((longint'(1) << pts_pkg::FRAC_BITS) - 1));
    endfunction

    function automatic speed_result_t predict_target_speed(pts_pkg::item_t it);
        speed_result_t r;
        longint rows;
        longint cols;
        longint ang;
        longint stp;
        longint pos;
        longint row;
        longint res;
        r.speed = '0;
        r.empty = 1'b0;
        rows = (rows_reg > pts_pkg::MAX_ROWS) ? pts_pkg::MAX_ROWS : rows_reg;
        cols = (cols_reg > pts_pkg::MAX_COLUMNS) ? pts_pkg::MAX_COLUMNS : cols_reg;
        if (it.action == pts_pkg::ACT_WRITE)
        begin
            speed_table_copy[it.entry_index] = it.entry_value;
            return r;
        end
        if (rows == 0 || cols == 0)
        begin
            r.speed = pts_pkg::EMPTY_SPEED;
            r.empty = 1'b1;
            return r;
        end
        if (it.wind_speed < 0)
            return r;
        ang = longint'(it.wind_angle) % pts_pkg::FULL_TURN;
        if (ang < 0)
            ang += pts_pkg::FULL_TURN;
        stp = (step_reg == 0) ? 1 : step_reg;
        pos = (longint'(it.wind_speed) <<< pts_pkg::FRAC_BITS) / stp;
        row = pos >>> pts_pkg::FRAC_BITS;
        if (row >= rows)
            res = speed_in_row(rows, ang, cols);
        else
            res = mix(speed_in_row(row, ang, cols), speed_in_row(row + 1, ang, cols),
                      pos & ((longint'(1) << pts_pkg::FRAC_BITS) - 1));
        r.speed = pts_pkg::SPEED_W'(res);
        return r;
    endfunction

    // receiver: alternate free-running and stalling stretches
    int  stall_left = 0;
    bit  stalling = 1'b0;
    always @(posedge clk)
    begin
        speed_result_t exp_r;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                exp_r = pending_speeds.pop_front();
                if (out_ch.target_speed !== exp_r.speed)
                begin
                    $error("target_speed expected %0d actual %0d", exp_r.speed,
                           out_ch.target_speed);
                    errors++;
                end
                if (out_ch.table_empty !== exp_r.empty)
                begin
                    $error("table_empty expected %0d actual %0d", exp_r.empty,
                           out_ch.table_empty);
                    errors++;
                end
            end
        end
        if (stall_left == 0)
        begin
            stalling <= ~stalling;
            stall_left <= $urandom_range(20, 150);
        end
        else
            stall_left <= stall_left - 1;
        out_ch.ready <= stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    task automatic send_item(pts_pkg::item_t it);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= it.action;
        in_ch.entry_index <= it.entry_index;
        in_ch.entry_value <= it.entry_value;
        in_ch.wind_speed  <= it.wind_speed;
        in_ch.wind_angle  <= it.wind_angle;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_speeds.push_back(predict_target_speed(it));
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apply_config(longint stp, longint rows, longint cols);
        hold_until_drained();
        cfg_write <= 1'b1;
        cfg_index <= pts_pkg::CFG_SPEED_STEP;
        cfg_data  <= pts_pkg::CFG_DATA_W'(stp);
        @(posedge clk);
        cfg_index <= pts_pkg::CFG_SPEED_ROWS;
        cfg_data  <= pts_pkg::CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= pts_pkg::CFG_ANGLE_COLUMNS;
        cfg_data  <= pts_pkg::CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_write <= 1'b0;
        step_reg = stp & 64'h7FFF_FFFF;
        rows_reg = rows & 64'h3F;
        cols_reg = cols & 64'h7F;
    endtask

    function automatic pts_pkg::item_t make_query(longint ws, longint ang);
        pts_pkg::item_t it;
        it.action      = pts_pkg::ACT_QUERY;
        it.entry_index = pts_pkg::INDEX_W'($urandom);
        it.entry_value = pts_pkg::VALUE_W'($urandom);
        it.wind_speed  = pts_pkg::WSPEED_W'(ws);
        it.wind_angle  = pts_pkg::WANGLE_W'(ang);
        return it;
    endfunction

    function automatic pts_pkg::item_t make_write(longint idx, longint val);
        pts_pkg::item_t it;
        it.action      = pts_pkg::ACT_WRITE;
        it.entry_index = pts_pkg::INDEX_W'(idx);
        it.entry_value = pts_pkg::VALUE_W'(val);
        it.wind_speed  = pts_pkg::WSPEED_W'($urandom);
        it.wind_angle  = pts_pkg::WANGLE_W'($urandom);
        return it;
    endfunction

    task automatic test_empty_at_reset();
        send_item(make_query(65536, 0));
        send_item(make_query(-1, 100));
    endtask

    // fill every entry that the later configurations can reach
    task automatic test_table_fill();
        for (int i = 0; i < FILL_ENTRIES; i++)
            send_item(make_write(i, $urandom));
    endtask

    task automatic test_directed();
        apply_config(65536, 4, 8);
        send_item(make_write(0, 0));
        send_item(make_write(2047, 2147483647));
        send_item(make_write(1, 2147483647));
        send_item(make_query(0, 0));
        send_item(make_query(2147483647, 0));
        send_item(make_query(-2147483648, 0));
        send_item(make_query(-1, 0));
        send_item(make_query(4 * 65536, 23592959));
        send_item(make_query(4 * 65536 - 1, -23592960));
        send_item(make_query(65536 + 32768, 45 * 65536 + 1));
        send_item(make_query(32768, 23592959));
        send_item(make_query(2 * 65536, -1));
        send_item(make_write(0, 2147483647));
        send_item(make_query(32768, 0));
        apply_config(0, 8, 8);
        send_item(make_query(5, 90 * 65536));
        apply_config(65536, 0, 8);
        send_item(make_query(65536, 0));
        apply_config(65536, 8, 0);
        send_item(make_query(65536, 0));
        send_item(make_write(5, 12345));
    endtask

    task automatic random_phase(longint stp, longint rows, longint cols, int n);
        longint         lim;
        longint         ws;
        longint         r;
        pts_pkg::item_t it;
        apply_config(stp, rows, cols);
        r = (rows > pts_pkg::MAX_ROWS) ? pts_pkg::MAX_ROWS : rows;
        lim = ((stp == 0) ? 1 : stp) * (r + 1);
        if (lim > 64'h7FFF_FFFF)
            lim = 64'h7FFF_FFFF;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                it = make_write($urandom_range(0, 2047), $urandom);
            else
            begin
                case ($urandom_range(0, 9))
                    0: ws = longint'($signed($urandom));
                    1: ws = -longint'($urandom_range(1, 32'h7FFF_FFFF)) - 1;
                    default: ws = longint'({$urandom, $urandom} % (lim + 1));
                endcase
                it = make_query(ws, longint'($urandom_range(0, 47185919)) - 23592960);
            end
            send_item(it);
            if (i == n / 2 && $urandom_range(0, 1) == 0)
                hold_until_drained();
        end
    endtask

    task automatic test_random();
        random_phase(65536, 8, 64, 70);
        random_phase(1, 1, 1, 30);
        random_phase(0, 63, 16, 40);
        random_phase(0, 8, 127, 40);
        random_phase(2147483647, 8, 64, 30);
        gaps_on = 1'b0;
        random_phase(3 * 65536 + 12345, $urandom_range(1, 8), $urandom_range(1, 64), 50);
        gaps_on = 1'b1;
        random_phase($urandom_range(1, 20 * 65536), $urandom_range(1, 8),
                     $urandom_range(1, 127), 40);
        random_phase($urandom_range(1, 32'h7FFF_FFFF), 7, 3, 30);
        random_phase(65536, 0, 0, 10);
    endtask

    task automatic test_pause_mid_stream();
        apply_config(2 * 65536, 16, 32);
        for (int i = 0; i < 40; i++)
        begin
            send_item(make_query($urandom_range(0, 40 * 65536),
                                 longint'($urandom_range(0, 47185919)) - 23592960));
            if (i % 10 == 9)
                hold_until_drained();
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.action = pts_pkg::ACT_WRITE;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        in_ch.wind_speed = '0;
        in_ch.wind_angle = '0;
        cfg_write = 1'b0;
        cfg_index = pts_pkg::CFG_SPEED_STEP;
        cfg_data = '0;
        step_reg = 65536;
        rows_reg = 0;
        cols_reg = 0;
        foreach (speed_table_copy[i])
            speed_table_copy[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_at_reset();
        test_table_fill();
        test_directed();
        test_random();
        test_pause_mid_stream();
        hold_until_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
